>>> hw/rtl/amq_pkg.sv
// Shared types and codes for the addressable min priority queue.
// Used by amq_cell and addressable_min_priority_queue; depends on nothing.
package amq_pkg;

  localparam int KEY_W  = 32;
  localparam int PRIO_W = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 7;

  // Request kinds
  localparam logic [FUNC_W-1:0] FUNC_INSERT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXTRACT  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_DECREASE = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

  // Commands broadcast to every cell of the row
  typedef struct packed {
    logic lookup;  // latch key match flag
    logic del;     // close the gap left by the removed entry
    logic ins;     // open a gap and place the new entry
  } cell_ctl_t;

endpackage

>>> hw/rtl/amq_cell.sv
// One slot of the sorted entry row: key, priority, valid and match flag.
// Depends on amq_pkg; instantiated in a row by addressable_min_priority_queue.
module amq_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  amq_pkg::cell_ctl_t                   ctl,
  input  logic [amq_pkg::KEY_W-1:0]            find_key,
  input  logic signed [amq_pkg::PRIO_W-1:0]    new_prio,
  input  logic [amq_pkg::KEY_W-1:0]            left_key,
  input  logic signed [amq_pkg::PRIO_W-1:0]    left_prio,
  input  logic                                 left_valid,
  input  logic                                 left_place,
  input  logic [amq_pkg::KEY_W-1:0]            right_key,
  input  logic signed [amq_pkg::PRIO_W-1:0]    right_prio,
  input  logic                                 right_valid,
  input  logic                                 gone_in,
  input  logic signed [amq_pkg::PRIO_W-1:0]    pick_in,
  output logic [amq_pkg::KEY_W-1:0]            key,
  output logic signed [amq_pkg::PRIO_W-1:0]    prio,
  output logic                                 valid,
  output logic                                 place,
  output logic                                 gone_out,
  output logic signed [amq_pkg::PRIO_W-1:0]    pick_out
);

  logic hit;

  // New entry belongs here: free slot, or strictly lower than what sits here
  assign place    = !valid || (new_prio < prio);
  // Removed entry is in this slot or an earlier one
  assign gone_out = gone_in | hit;
  // Forward the matched entry's priority down the row
  assign pick_out = pick_in | (hit ? prio : '0);

  // Control state: valid and match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctl.lookup) begin
        hit <= valid && (key == find_key);
      end
      if (ctl.del && gone_out) begin
        valid <= right_valid;
      end else if (ctl.ins) begin
        if (left_place) begin
          valid <= left_valid;
        end else if (place) begin
          valid <= 1'b1;
        end
      end
    end
  end

  // Payload: shift left on delete, shift right behind the insert point
  always_ff @(posedge clk) begin
    if (ctl.del && gone_out) begin
      key  <= right_key;
      prio <= right_prio;
    end else if (ctl.ins) begin
      if (left_place) begin
        key  <= left_key;
        prio <= left_prio;
      end else if (place) begin
        key  <= find_key;
        prio <= new_prio;
      end
    end
  end

endmodule

>>> hw/rtl/addressable_min_priority_queue.sv
// Addressable min priority queue: a row of cells kept sorted by priority.
// Depends on amq_pkg and amq_cell.
//
// A request is taken when start is high and busy is low. Insert, remove and
// extract-min pass the lookup and execute steps before the result word is
// registered; a successful decrease-key adds a re-insert step. The lookup step
// latches the key match flag in every cell; a successful execute shifts the
// row once (left to close a gap, right to open one), and the re-insert step
// shifts it again to re-place the entry. The result word is on status, out_key,
// out_priority and occupancy for exactly one cycle, marked by strobe, and must
// be taken then; busy drops in that same cycle, so the next request can start
// right away. occupancy carries the low seven bits of the entry count.
module addressable_min_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [amq_pkg::FUNC_W-1:0]           func,
  input  logic [amq_pkg::KEY_W-1:0]            item_key,
  input  logic signed [amq_pkg::PRIO_W-1:0]    item_priority,
  output logic                                 strobe,
  output logic [amq_pkg::STAT_W-1:0]           status,
  output logic [amq_pkg::KEY_W-1:0]            out_key,
  output logic signed [amq_pkg::PRIO_W-1:0]    out_priority,
  output logic [amq_pkg::OCC_W-1:0]            occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_EXEC, S_INS} state_t;

  state_t                            state, state_next;
  logic [amq_pkg::FUNC_W-1:0]        op;
  logic [amq_pkg::KEY_W-1:0]         key_r;
  logic signed [amq_pkg::PRIO_W-1:0] prio_r;
  logic [CNT_W-1:0]                  count, count_next;

  logic                              emit;
  logic [amq_pkg::STAT_W-1:0]        status_next;
  logic [amq_pkg::KEY_W-1:0]         okey_next;
  logic signed [amq_pkg::PRIO_W-1:0] oprio_next;
  amq_pkg::cell_ctl_t                ctl;
  logic                              head_gone;

  // Row wiring, one element per cell
  logic [amq_pkg::KEY_W-1:0]         c_key   [CAPACITY];
  logic signed [amq_pkg::PRIO_W-1:0] c_prio  [CAPACITY];
  logic signed [amq_pkg::PRIO_W-1:0] c_pick  [CAPACITY];
  logic [CAPACITY-1:0]               c_valid;
  logic [CAPACITY-1:0]               c_place;
  logic [CAPACITY-1:0]               c_gone;

  logic                              found;
  logic signed [amq_pkg::PRIO_W-1:0] hit_prio;

  assign found    = c_gone[CAPACITY-1];
  assign hit_prio = c_pick[CAPACITY-1];
  assign busy     = (state != S_IDLE);

  // Build the row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [amq_pkg::KEY_W-1:0]         l_key, r_key;
    logic signed [amq_pkg::PRIO_W-1:0] l_prio, r_prio, p_in;
    logic                              l_valid, l_place, r_valid, g_in;

    if (i == 0) begin : g_head
      assign l_key   = '0;
      assign l_prio  = '0;
      assign l_valid = 1'b0;
      assign l_place = 1'b0;
      assign g_in    = head_gone;
      assign p_in    = '0;
    end else begin : g_body
      assign l_key   = c_key[i-1];
      assign l_prio  = c_prio[i-1];
      assign l_valid = c_valid[i-1];
      assign l_place = c_place[i-1];
      assign g_in    = c_gone[i-1];
      assign p_in    = c_pick[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_key   = '0;
      assign r_prio  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_key   = c_key[i+1];
      assign r_prio  = c_prio[i+1];
      assign r_valid = c_valid[i+1];
    end

    amq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .find_key    (key_r),
      .new_prio    (prio_r),
      .left_key    (l_key),
      .left_prio   (l_prio),
      .left_valid  (l_valid),
      .left_place  (l_place),
      .right_key   (r_key),
      .right_prio  (r_prio),
      .right_valid (r_valid),
      .gone_in     (g_in),
      .pick_in     (p_in),
      .key         (c_key[i]),
      .prio        (c_prio[i]),
      .valid       (c_valid[i]),
      .place       (c_place[i]),
      .gone_out    (c_gone[i]),
      .pick_out    (c_pick[i])
    );
  end

  // Sequence one request and decide its result
  always_comb begin
    state_next  = state;
    count_next  = count;
    emit        = 1'b0;
    status_next = amq_pkg::STAT_DONE;
    okey_next   = '0;
    oprio_next  = '0;
    ctl         = '0;
    head_gone   = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        ctl.lookup = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
        emit       = 1'b1;
        case (op)
          amq_pkg::FUNC_INSERT: begin
            if (found) begin
              status_next = amq_pkg::STAT_IGNORED;
            end else if (count == CNT_W'(CAPACITY)) begin
              status_next = amq_pkg::STAT_FULL;
            end else begin
              ctl.ins    = 1'b1;
              count_next = count + CNT_W'(1);
            end
          end
          amq_pkg::FUNC_REMOVE: begin
            if (found) begin
              ctl.del    = 1'b1;
              count_next = count - CNT_W'(1);
            end else begin
              status_next = amq_pkg::STAT_IGNORED;
            end
          end
          amq_pkg::FUNC_EXTRACT: begin
            if (count == '0) begin
              status_next = amq_pkg::STAT_EMPTY;
            end else begin
              head_gone  = 1'b1;
              ctl.del    = 1'b1;
              okey_next  = c_key[0];
              oprio_next = c_prio[0];
              count_next = count - CNT_W'(1);
            end
          end
          amq_pkg::FUNC_DECREASE: begin
            if (found && (prio_r < hit_prio)) begin
              ctl.del    = 1'b1;
              count_next = count - CNT_W'(1);
              emit       = 1'b0;
              state_next = S_INS;
            end else begin
              status_next = amq_pkg::STAT_IGNORED;
            end
          end
          default: begin
            status_next = amq_pkg::STAT_IGNORED;
          end
        endcase
      end
      S_INS: begin
        ctl.ins    = 1'b1;
        count_next = count + CNT_W'(1);
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, request word and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= emit;
    end
    if (state == S_IDLE && start) begin
      op     <= func;
      key_r  <= item_key;
      prio_r <= item_priority;
    end
    if (emit) begin
      status       <= status_next;
      out_key      <= okey_next;
      out_priority <= oprio_next;
      occupancy    <= amq_pkg::OCC_W'(count_next);
    end
  end

  // Results only leave from the execute or re-insert step
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(state) == S_EXEC || $past(state) == S_INS))
    else $error("result strobe without an execute step");

  // An accepted request always starts with the lookup step
  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_LOOK))
    else $error("accepted request did not enter lookup");

  // Filled cells match the entry count
  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    ($countones(c_valid) == count))
    else $error("cell valid flags disagree with entry count");

  // Count never exceeds the row length
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(CAPACITY)))
    else $error("entry count above capacity");

endmodule

>>> verif/amq_checker.sv
// Checker for the addressable min priority queue: predicts each result word
// from the accepted requests and compares it with the block's output ports.
// Depends on amq_pkg for widths, request kinds and status codes.
module amq_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [amq_pkg::FUNC_W-1:0]        func,
  input  logic [amq_pkg::KEY_W-1:0]         item_key,
  input  logic signed [amq_pkg::PRIO_W-1:0] item_priority,
  input  logic                              strobe,
  input  logic [amq_pkg::STAT_W-1:0]        status,
  input  logic [amq_pkg::KEY_W-1:0]         out_key,
  input  logic signed [amq_pkg::PRIO_W-1:0] out_priority,
  input  logic [amq_pkg::OCC_W-1:0]         occupancy,
  output int                                fail_count,
  output int                                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [amq_pkg::KEY_W-1:0]         key;
    logic signed [amq_pkg::PRIO_W-1:0] prio;
  } held_entry_t;

  typedef struct {
    logic [amq_pkg::STAT_W-1:0]        stat;
    logic [amq_pkg::KEY_W-1:0]         key;
    logic signed [amq_pkg::PRIO_W-1:0] prio;
    logic [amq_pkg::OCC_W-1:0]         occ;
  } reply_word_t;

  // Entries in the order their priority was set, earliest first
  held_entry_t held_q[$];
  // Result words still to come, oldest first
  reply_word_t awaited_q[$];

  function automatic int slot_of(input logic [amq_pkg::KEY_W-1:0] key);
    foreach (held_q[i]) begin
      if (held_q[i].key == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the held entries and return the word it yields
  function automatic reply_word_t serve_request(
    input logic [amq_pkg::FUNC_W-1:0]        kind,
    input logic [amq_pkg::KEY_W-1:0]         key,
    input logic signed [amq_pkg::PRIO_W-1:0] prio
  );
    reply_word_t r;
    int pos;
    int best;
    r = '{default: '0};
    r.stat = amq_pkg::STAT_DONE;
    pos = slot_of(key);
    case (kind)
      amq_pkg::FUNC_INSERT: begin
        if (pos >= 0) r.stat = amq_pkg::STAT_IGNORED;
        else if (held_q.size() >= CAPACITY) r.stat = amq_pkg::STAT_FULL;
        else held_q.push_back('{key, prio});
      end
      amq_pkg::FUNC_REMOVE: begin
        if (pos >= 0) held_q.delete(pos);
        else r.stat = amq_pkg::STAT_IGNORED;
      end
      amq_pkg::FUNC_EXTRACT: begin
        if (held_q.size() == 0) begin
          r.stat = amq_pkg::STAT_EMPTY;
        end else begin
          // strict compare keeps the earliest-set entry among equals
          best = 0;
          for (int i = 1; i < held_q.size(); i++) begin
            if (held_q[i].prio < held_q[best].prio) best = i;
          end
          r.key  = held_q[best].key;
          r.prio = held_q[best].prio;
          held_q.delete(best);
        end
      end
      default: begin
        // a lowered priority counts as set now: move the entry to the end
        if (pos >= 0 && prio < held_q[pos].prio) begin
          held_q.delete(pos);
          held_q.push_back('{key, prio});
        end else begin
          r.stat = amq_pkg::STAT_IGNORED;
        end
      end
    endcase
    r.occ = amq_pkg::OCC_W'(held_q.size());
    return r;
  endfunction

  always @(posedge clk) begin
    reply_word_t want;
    if (!rst) begin
      // check the result word that ends with this edge
      if (strobe) begin
        if (awaited_q.size() == 0) begin
          fail_count++;
          $display("%0t: result word with none awaited: status=%0d key=%h prio=%0d occ=%0d",
                   $time, status, out_key, out_priority, occupancy);
        end else begin
          want = awaited_q.pop_front();
          if (status !== want.stat) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.stat, status);
          end
          if (out_key !== want.key) begin
            fail_count++;
            $display("%0t: out_key expected %h actual %h", $time, want.key, out_key);
          end
          if (out_priority !== want.prio) begin
            fail_count++;
            $display("%0t: out_priority expected %0d actual %0d",
                     $time, want.prio, out_priority);
          end
          if (occupancy !== want.occ) begin
            fail_count++;
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occupancy);
          end
        end
      end
      // predict the word for a request taken at this edge
      if (start && !busy) awaited_q.push_back(serve_request(func, item_key, item_priority));
      pending = awaited_q.size();
    end
  end

endmodule

>>> verif/tb_addressable_min_priority_queue.sv
// Testbench top for the addressable min priority queue: drives directed and
// random requests with sender gaps and gives the verdict.
// Depends on amq_pkg, the block under test and amq_checker.
module tb_addressable_min_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY   = 64;
  localparam int POOL_SIZE  = 96;
  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 160;
  localparam int LIMIT_CYC  = 200000;

  // Request mixes per phase
  localparam int MODE_FILL  = 0;
  localparam int MODE_CHURN = 1;
  localparam int MODE_DRAIN = 2;
  localparam int INS_CUT[3] = '{80, 35, 15};
  localparam int REM_CUT[3] = '{87, 55, 45};
  localparam int EXT_CUT[3] = '{93, 75, 85};
  localparam int IDLE_PCT[4] = '{0, 57, 0, 14};

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              start;
  logic                              busy;
  logic [amq_pkg::FUNC_W-1:0]        func;
  logic [amq_pkg::KEY_W-1:0]         item_key;
  logic signed [amq_pkg::PRIO_W-1:0] item_priority;
  logic                              strobe;
  logic [amq_pkg::STAT_W-1:0]        status;
  logic [amq_pkg::KEY_W-1:0]         out_key;
  logic signed [amq_pkg::PRIO_W-1:0] out_priority;
  logic [amq_pkg::OCC_W-1:0]         occupancy;
  int                                fail_count;
  int                                pending;

  int                                idle_pct;
  logic [amq_pkg::KEY_W-1:0]         key_pool [POOL_SIZE];

  always #10 clk = ~clk;

  addressable_min_priority_queue #(.CAPACITY(CAPACITY)) dut (
    .clk, .rst, .start, .busy, .func, .item_key, .item_priority,
    .strobe, .status, .out_key, .out_priority, .occupancy
  );

  amq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk, .rst, .start, .busy, .func, .item_key, .item_priority,
    .strobe, .status, .out_key, .out_priority, .occupancy,
    .fail_count, .pending
  );

  // Offer one request word and hold it until the block takes it
  task automatic send_word(input logic [amq_pkg::FUNC_W-1:0] kind,
                           input logic [amq_pkg::KEY_W-1:0] key,
                           input logic signed [amq_pkg::PRIO_W-1:0] prio);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    func          <= kind;
    item_key      <= key;
    item_priority <= prio;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [amq_pkg::FUNC_W-1:0] pick_func(input int mode);
    int roll;
    roll = $urandom_range(99);
    if (roll < INS_CUT[mode]) return amq_pkg::FUNC_INSERT;
    if (roll < REM_CUT[mode]) return amq_pkg::FUNC_REMOVE;
    if (roll < EXT_CUT[mode]) return amq_pkg::FUNC_EXTRACT;
    return amq_pkg::FUNC_DECREASE;
  endfunction

  // Mostly pool keys so requests hit held entries; some stray keys
  function automatic logic [amq_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 90) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Narrow band for ties, extremes, and full-range values
  function automatic logic signed [amq_pkg::PRIO_W-1:0] pick_priority();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return $urandom_range(16) - 8;
    if (roll < 55) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int mode;
    rst           <= 1'b1;
    start         <= 1'b0;
    func          <= amq_pkg::FUNC_INSERT;
    item_key      <= '0;
    item_priority <= '0;
    idle_pct = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty store, absent keys, extremes, ties and decrease rules
    send_word(amq_pkg::FUNC_EXTRACT,  $urandom,      $urandom);
    send_word(amq_pkg::FUNC_REMOVE,   32'h1234_5678, '0);
    send_word(amq_pkg::FUNC_DECREASE, 32'h1234_5678, 32'sh8000_0000);
    send_word(amq_pkg::FUNC_INSERT,   32'h0000_0000, 32'sh8000_0000);
    send_word(amq_pkg::FUNC_INSERT,   32'hffff_ffff, 32'sh7fff_ffff);
    send_word(amq_pkg::FUNC_INSERT,   32'h0000_0000, 32'sd5);
    send_word(amq_pkg::FUNC_INSERT,   32'ha5a5_a5a5, '0);
    send_word(amq_pkg::FUNC_INSERT,   32'h5a5a_5a5a, '0);
    send_word(amq_pkg::FUNC_DECREASE, 32'hffff_ffff, 32'sh7fff_ffff);
    send_word(amq_pkg::FUNC_DECREASE, 32'hffff_ffff, '0);
    send_word(amq_pkg::FUNC_DECREASE, 32'h5a5a_5a5a, '0);
    send_word(amq_pkg::FUNC_DECREASE, 32'h0000_0000, 32'sh8000_0000);
    repeat (4) send_word(amq_pkg::FUNC_EXTRACT, $urandom, $urandom);
    send_word(amq_pkg::FUNC_EXTRACT,  $urandom,      $urandom);
    send_word(amq_pkg::FUNC_INSERT,   32'h0000_0001, 32'sd5);
    send_word(amq_pkg::FUNC_REMOVE,   32'h0000_0001, '0);
    send_word(amq_pkg::FUNC_REMOVE,   32'h0000_0001, '0);
    send_word(amq_pkg::FUNC_INSERT,   32'h0000_0007, -32'sd3);
    send_word(amq_pkg::FUNC_DECREASE, 32'h0000_0007, 32'sh8000_0000);
    send_word(amq_pkg::FUNC_EXTRACT,  $urandom,      $urandom);

    // Random: fill, churn and drain phases under each sender gap rate
    for (int ph = 0; ph < PHASES; ph++) begin
      mode     = ph % 3;
      idle_pct = IDLE_PCT[ph % 4];
      for (int n = 0; n < PHASE_LEN; n++) send_word(pick_func(mode), pick_key(), pick_priority());
    end
    start <= 1'b0;

    // Wait out the last result words, then let the block settle
    for (int w = 0; w < 100 && pending != 0; w++) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(LIMIT_CYC * 20);
    $display("Regression FAIL");
    $finish;
  end

endmodule
